// File: src/jacs_pkg.sv
// ----------------------------------------------------------------------------
// jacs_pkg: shared types and constants for the joystick axis calibrator
// Field widths, register layout, reset calibrations and the request formats
// passed between the front end, the queue and the scaling back end.
// ----------------------------------------------------------------------------
package jacs_pkg;

  // Sample and calibration field widths
  localparam int SAMPLE_BITS = 12;
  localparam int CAL_W       = 13;
  localparam int NUM_CH      = 4;
  localparam int REG_W       = 3 * CAL_W;

  // Result field widths
  localparam int LEVER_W = 7;
  localparam int AXIS_W  = 8;

  // Defaults for top level parameters
  localparam int FULL_SCALE_DEF  = 100;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Channel roles: channel 1 is the lever, channels 0 and 2 are inverted axes
  localparam int               CH_LEVER    = 1;
  localparam logic [NUM_CH-1:0] AXIS_INVERT = 4'b0101;

  // Configuration port layout: 64-bit registers at 8-byte strides
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = $clog2(NUM_CH);
  localparam int APB_ADDR_W = REG_IDX_W + 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAL_CH0 = 2'd0,
    REG_CAL_CH1 = 2'd1,
    REG_CAL_CH2 = 2'd2,
    REG_CAL_CH3 = 2'd3
  } reg_idx_t;

  // Calibration register: max in the top field, min in the bottom one
  typedef struct packed {
    logic [CAL_W-1:0] cal_max;
    logic [CAL_W-1:0] cal_mid;
    logic [CAL_W-1:0] cal_min;
  } cal_t;

  localparam cal_t CAL_RESET_CENTRED = '{cal_max: 13'd4096, cal_mid: 13'd2048,
                                         cal_min: 13'd0};
  localparam cal_t CAL_RESET_LEVER   = '{cal_max: 13'd4096, cal_mid: 13'd0,
                                         cal_min: 13'd0};

  // Input request: four raw samples
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_ch0;
    logic [SAMPLE_BITS-1:0] raw_ch1;
    logic [SAMPLE_BITS-1:0] raw_ch2;
    logic [SAMPLE_BITS-1:0] raw_ch3;
  } in_item_t;

  // Result request: four scaled values
  typedef struct packed {
    logic        [LEVER_W-1:0] out_lever;
    logic signed [AXIS_W-1:0]  out_first;
    logic signed [AXIS_W-1:0]  out_second;
    logic signed [AXIS_W-1:0]  out_third;
  } out_item_t;

  // Position of a clamped sample relative to the centre
  typedef enum logic [1:0] {
    SIDE_MID  = 2'd0,
    SIDE_UP   = 2'd1,
    SIDE_DOWN = 2'd2
  } side_t;

  // Classified channel as handed from front end to back end
  typedef struct packed {
    logic [CAL_W-1:0] val;
    side_t            side;
  } chan_class_t;

  typedef chan_class_t [NUM_CH-1:0] front_item_t;

endpackage

// File: src/joystick_axis_calibrate_scale_core.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale_core: four-channel stick calibration
// Holds the calibration registers and joins intake, queue and scaling.
// ----------------------------------------------------------------------------
// Accepts one set of four samples per clock while in_stall is low and
// returns one result per set, in order. Each result passes the intake
// register, which loads at the accept, then one queue slot, one setup stage,
// one divider stage per quotient bit in each channel's divider lane, and the
// output register. Calibration registers sit at byte addresses 0, 8, 16 and
// 24 and should be written only while no request is in flight.
module joystick_axis_calibrate_scale_core import jacs_pkg::*; #(
  parameter int FULL_SCALE  = FULL_SCALE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cal_t [NUM_CH-1:0] cal_r;
  reg_idx_t          reg_idx;
  logic              wr_en;
  logic              push, push_ready, pop, empty;
  front_item_t       push_item, head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign prdata  = APB_DATA_W'(cal_r[reg_idx]);

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cal_r[c] <= (c == CH_LEVER) ? CAL_RESET_LEVER : CAL_RESET_CENTRED;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_CAL_CH0: cal_r[0] <= cal_t'(pwdata[REG_W-1:0]);
        REG_CAL_CH1: cal_r[1] <= cal_t'(pwdata[REG_W-1:0]);
        REG_CAL_CH2: cal_r[2] <= cal_t'(pwdata[REG_W-1:0]);
        REG_CAL_CH3: cal_r[3] <= cal_t'(pwdata[REG_W-1:0]);
        default: ;
      endcase
    end
  end

  jacs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  jacs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  jacs_back #(
    .FULL_SCALE (FULL_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: src/jacs_front.sv
// ----------------------------------------------------------------------------
// jacs_front: sample intake and classification
// Clamps each raw sample to its calibrated range, sorts it against the centre
// and holds the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module jacs_front import jacs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cal_t [NUM_CH-1:0]       cal,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_item_t                in_data,
  output logic                    push,
  input  logic                    push_ready,
  output front_item_t             push_item
);

  localparam int CMP_W = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;

  logic        item_vld_r;
  front_item_t item_r;
  front_item_t item_nxt;
  logic        adv;
  logic [SAMPLE_BITS-1:0] raw [NUM_CH];

  // Gather samples by channel number
  always_comb begin
    raw[0] = in_data.raw_ch0;
    raw[1] = in_data.raw_ch1;
    raw[2] = in_data.raw_ch2;
    raw[3] = in_data.raw_ch3;
  end

  // Clamp low bound first, then high bound, and classify against centre
  always_comb begin
    logic [CMP_W-1:0] v;
    logic [CAL_W-1:0] cv;
    for (int c = 0; c < NUM_CH; c++) begin
      v = CMP_W'(raw[c]);
      if (v < CMP_W'(cal[c].cal_min)) v = CMP_W'(cal[c].cal_min);
      if (v > CMP_W'(cal[c].cal_max)) v = CMP_W'(cal[c].cal_max);
      cv = CAL_W'(v);
      item_nxt[c].val = cv;
      if (c == CH_LEVER || cv > cal[c].cal_mid) begin
        item_nxt[c].side = SIDE_UP;
      end else if (cv < cal[c].cal_mid) begin
        item_nxt[c].side = SIDE_DOWN;
      end else begin
        item_nxt[c].side = SIDE_MID;
      end
    end
  end

  assign adv       = !item_vld_r || push_ready;
  assign in_stall  = !adv;
  assign push      = item_vld_r && push_ready;
  assign push_item = item_r;

  // Advance the holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (adv) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      item_r <= item_nxt;
    end
  end

  // A held request stays put until the queue takes it
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && !push_ready) |=> (item_vld_r && $stable(item_r)))
    else $error("front request changed while the queue was full");

endmodule

// File: src/jacs_queue.sv
// ----------------------------------------------------------------------------
// jacs_queue: short queue between front end and back end
// Small register queue so intake and scaling can stall independently.
// ----------------------------------------------------------------------------
module jacs_queue import jacs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        push_ready,
  input  front_item_t push_item,
  input  logic        pop,
  output logic        empty,
  output front_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign empty      = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !push_ready))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

// File: src/jacs_div.sv
// ----------------------------------------------------------------------------
// jacs_div: pipelined restoring divider lane
// Resolves one quotient bit per stage; the quotient is known to fit QW bits.
// A preset quotient with a zero dividend and nonzero divisor passes unchanged.
// ----------------------------------------------------------------------------
module jacs_div #(
  parameter int QW    = 7,
  parameter int NUM_W = 20,
  parameter int DIV_W = 13
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DIV_W-1:0] in_div,
  input  logic [QW-1:0]    in_quo,
  output logic [QW-1:0]    out_quo
);

  logic [NUM_W-1:0] rem_r   [QW];
  logic [DIV_W-1:0] div_r   [QW];
  logic [QW-1:0]    quo_r   [QW];
  logic [NUM_W-1:0] rem_in  [QW];
  logic [DIV_W-1:0] div_in  [QW];
  logic [QW-1:0]    quo_in  [QW];
  logic [NUM_W-1:0] rem_nxt [QW];
  logic [QW-1:0]    quo_nxt [QW];

  // Compare and subtract the shifted divisor, most significant bit first
  always_comb begin
    logic [NUM_W-1:0] shifted;
    logic             ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_in[k] = in_num;
        div_in[k] = in_div;
        quo_in[k] = in_quo;
      end else begin
        rem_in[k] = rem_r[k-1];
        div_in[k] = div_r[k-1];
        quo_in[k] = quo_r[k-1];
      end
      shifted    = NUM_W'(div_in[k]) << (QW - 1 - k);
      ge         = (rem_in[k] >= shifted);
      rem_nxt[k] = ge ? (rem_in[k] - shifted) : rem_in[k];
      quo_nxt[k] = quo_in[k] | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        div_r[k] <= div_in[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign out_quo = quo_r[QW-1];

endmodule

// File: src/jacs_back.sv
// ----------------------------------------------------------------------------
// jacs_back: scaling back end
// Forms distance and span per channel, catches zero span and saturation,
// runs the four divider lanes in step and registers the results, axes signed.
// ----------------------------------------------------------------------------
module jacs_back import jacs_pkg::*; #(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cal_t [NUM_CH-1:0] cal,
  input  front_item_t       head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int QW    = $clog2(FULL_SCALE + 1);
  localparam int NUM_W = CAL_W + QW;

  logic                adv;
  logic                s0_vld_r;
  logic [NUM_W-1:0]    s0_num_r [NUM_CH];
  logic [CAL_W-1:0]    s0_div_r [NUM_CH];
  logic [QW-1:0]       s0_quo_r [NUM_CH];
  logic [NUM_CH-1:0]   s0_neg_r;
  logic [NUM_W-1:0]    s0_num_nxt [NUM_CH];
  logic [CAL_W-1:0]    s0_div_nxt [NUM_CH];
  logic [QW-1:0]       s0_quo_nxt [NUM_CH];
  logic [NUM_CH-1:0]   s0_neg_nxt;
  logic [QW-1:0]       lane_quo [NUM_CH];
  logic [QW-1:0]       ln_vld_r;
  logic [NUM_CH-1:0]   ln_neg_r [QW];
  logic                out_valid_r;
  out_item_t           out_data_r;
  out_item_t           out_data_nxt;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && !empty;

  // Pick distance and span for each side, preset quotient for special cases
  always_comb begin
    logic signed [CAL_W:0] v, lo, mid, hi, delta, span;
    logic                  zero, sat;
    for (int c = 0; c < NUM_CH; c++) begin
      v     = $signed({1'b0, head[c].val});
      lo    = $signed({1'b0, cal[c].cal_min});
      mid   = $signed({1'b0, cal[c].cal_mid});
      hi    = $signed({1'b0, cal[c].cal_max});
      delta = '0;
      span  = '0;
      zero  = 1'b0;
      if (c == CH_LEVER) begin
        delta = v - lo;
        span  = hi - lo;
      end else begin
        case (head[c].side)
          SIDE_UP: begin
            delta = v - mid;
            span  = hi - mid;
          end
          SIDE_DOWN: begin
            delta = mid - v;
            span  = mid - lo;
          end
          default: zero = 1'b1;
        endcase
      end
      zero = zero || (span <= 0);
      sat  = !zero && (delta >= span);
      if (zero || sat) begin
        s0_num_nxt[c] = '0;
        s0_div_nxt[c] = CAL_W'(1);
        s0_quo_nxt[c] = sat ? QW'(FULL_SCALE) : '0;
      end else begin
        s0_num_nxt[c] = NUM_W'(NUM_W'(delta[CAL_W-1:0]) * NUM_W'(FULL_SCALE));
        s0_div_nxt[c] = span[CAL_W-1:0];
        s0_quo_nxt[c] = '0;
      end
      s0_neg_nxt[c] = (c != CH_LEVER) &&
                      ((head[c].side == SIDE_DOWN) ^ AXIS_INVERT[c]);
    end
  end

  // Register the prepared dividends
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r <= s0_num_nxt;
      s0_div_r <= s0_div_nxt;
      s0_quo_r <= s0_quo_nxt;
      s0_neg_r <= s0_neg_nxt;
    end
  end

  // One divider lane per channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    jacs_div #(
      .QW    (QW),
      .NUM_W (NUM_W),
      .DIV_W (CAL_W)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .in_num  (s0_num_r[c]),
      .in_div  (s0_div_r[c]),
      .in_quo  (s0_quo_r[c]),
      .out_quo (lane_quo[c])
    );
  end

  // Carry valid and sign flags alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      ln_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= pop;
      ln_vld_r    <= {ln_vld_r[QW-2:0], s0_vld_r};
      out_valid_r <= ln_vld_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QW; k++) begin
        ln_neg_r[k] <= (k == 0) ? s0_neg_r : ln_neg_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Apply sign and trim to the result field widths
  always_comb begin
    logic [AXIS_W-1:0] m0, m2, m3;
    m0 = AXIS_W'(lane_quo[0]);
    m2 = AXIS_W'(lane_quo[2]);
    m3 = AXIS_W'(lane_quo[3]);
    out_data_nxt.out_lever  = LEVER_W'(lane_quo[CH_LEVER]);
    out_data_nxt.out_first  = ln_neg_r[QW-1][0] ? -m0 : m0;
    out_data_nxt.out_third  = ln_neg_r[QW-1][2] ? -m2 : m2;
    out_data_nxt.out_second = ln_neg_r[QW-1][3] ? -m3 : m3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled result blocks the queue read
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !pop)
    else $error("queue popped while result stalled");

  // Lane quotients never exceed full scale
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    ln_vld_r[QW-1] |-> ((lane_quo[0] <= QW'(FULL_SCALE)) &&
                        (lane_quo[1] <= QW'(FULL_SCALE)) &&
                        (lane_quo[2] <= QW'(FULL_SCALE)) &&
                        (lane_quo[3] <= QW'(FULL_SCALE))))
    else $error("divider lane quotient above full scale");

endmodule

// File: dv/joystick_axis_calibrate_scale_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale_core_checker: result predictor and compare
// Watches the calibration writes and both request channels. It keeps its own
// copy of the four calibrations and works out the scaled percentages for each
// accepted sample set. Each returned result is checked field by field against
// the oldest prediction. Mismatches and pending predictions go to the top.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_scale_core_checker import jacs_pkg::*; #(
  parameter int FULL_SCALE = FULL_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  localparam int REPORT_MAX = 40;

  cal_t      cal_reg [NUM_CH];
  out_item_t scaled_due_q [$];
  int        mismatches = 0;
  int        reports = 0;

  // Clamp to [min,max]: lower bound first, then upper, so min above max gives max
  function automatic longint clamp_to_cal(input logic [SAMPLE_BITS-1:0] raw, input cal_t c);
    longint v;
    v = longint'(raw);
    if (v < longint'(c.cal_min)) v = longint'(c.cal_min);
    if (v > longint'(c.cal_max)) v = longint'(c.cal_max);
    return v;
  endfunction

  // Scale a distance over a span, truncate, saturate; empty span gives 0
  function automatic longint pct_of_span(input longint delta, input longint span);
    longint m;
    if (span <= 0) return 0;
    m = (delta * FULL_SCALE) / span;
    if (m > FULL_SCALE) m = FULL_SCALE;
    return m;
  endfunction

  // Piecewise map about the centre, each side over its own half span
  function automatic longint axis_pct(input logic [SAMPLE_BITS-1:0] raw, input cal_t c);
    longint v;
    longint mid;
    v   = clamp_to_cal(raw, c);
    mid = longint'(c.cal_mid);
    if (v > mid) return pct_of_span(v - mid, longint'(c.cal_max) - mid);
    if (v < mid) return -pct_of_span(mid - v, mid - longint'(c.cal_min));
    return 0;
  endfunction

  // Predict one result from one sample set and the current calibrations
  function automatic out_item_t scale_sample_set(input in_item_t s);
    out_item_t r;
    cal_t      lev;
    longint    lever_pct;
    longint    first_pct;
    longint    second_pct;
    longint    third_pct;
    lev        = cal_reg[REG_CAL_CH1];
    lever_pct  = pct_of_span(clamp_to_cal(s.raw_ch1, lev) - longint'(lev.cal_min),
                             longint'(lev.cal_max) - longint'(lev.cal_min));
    first_pct  = -axis_pct(s.raw_ch0, cal_reg[REG_CAL_CH0]);
    second_pct = axis_pct(s.raw_ch3, cal_reg[REG_CAL_CH3]);
    third_pct  = -axis_pct(s.raw_ch2, cal_reg[REG_CAL_CH2]);
    r.out_lever  = lever_pct[LEVER_W-1:0];
    r.out_first  = first_pct[AXIS_W-1:0];
    r.out_second = second_pct[AXIS_W-1:0];
    r.out_third  = third_pct[AXIS_W-1:0];
    return r;
  endfunction

  // Compare one field, four-state, and report a difference
  task automatic check_field(input string name, input logic signed [AXIS_W:0] want,
                             input logic signed [AXIS_W:0] got);
    if (got !== want) begin
      mismatches++;
      if (reports < REPORT_MAX) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
      reports++;
    end
  endtask

  // Track calibration writes, queue predictions, retire results in order
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      cal_reg[REG_CAL_CH0] = CAL_RESET_CENTRED;
      cal_reg[REG_CAL_CH1] = CAL_RESET_LEVER;
      cal_reg[REG_CAL_CH2] = CAL_RESET_CENTRED;
      cal_reg[REG_CAL_CH3] = CAL_RESET_CENTRED;
      scaled_due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        cal_reg[paddr[APB_ADDR_W-1:3]] = pwdata[REG_W-1:0];
      end
      if (in_valid && !in_stall) begin
        scaled_due_q.push_back(scale_sample_set(in_data));
      end
      if (out_valid && !out_stall) begin
        if (scaled_due_q.size() == 0) begin
          mismatches++;
          if (reports < REPORT_MAX) begin
            $display("%0t: result with no request outstanding, expected none, actual %h",
                     $time, out_data);
          end
          reports++;
        end else begin
          want = scaled_due_q.pop_front();
          check_field("out_lever", (AXIS_W+1)'(want.out_lever),
                      (AXIS_W+1)'(out_data.out_lever));
          check_field("out_first", (AXIS_W+1)'(want.out_first),
                      (AXIS_W+1)'(out_data.out_first));
          check_field("out_second", (AXIS_W+1)'(want.out_second),
                      (AXIS_W+1)'(out_data.out_second));
          check_field("out_third", (AXIS_W+1)'(want.out_third),
                      (AXIS_W+1)'(out_data.out_third));
        end
      end
    end
    pending    <= scaled_due_q.size();
    fail_count <= mismatches;
  end

endmodule

// File: dv/joystick_axis_calibrate_scale_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_axis_calibrate_scale_core_tb: stimulus and verdict
// Drives sample sets and calibration writes into the stick calibrator with
// random idling on both channels. A short directed pass covers the field
// extremes and corner calibrations, then random phases reload all four
// calibrations and send samples aimed at the calibration points.
// ----------------------------------------------------------------------------
module joystick_axis_calibrate_scale_core_tb import jacs_pkg::*;;

  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SETS    = 170;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  in_item_t              in_data = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   in_gaps = 1'b1;
  bit   out_gaps = 1'b1;
  cal_t cal_now [NUM_CH];

  joystick_axis_calibrate_scale_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  joystick_axis_calibrate_scale_core_checker result_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Random calibration: half ordered, some raw, some inverted or off-centre
  function automatic cal_t pick_cal();
    cal_t        c;
    logic [63:0] w;
    int          lo;
    int          hi;
    w  = {$urandom(), $urandom()};
    lo = $urandom_range(0, 4000);
    hi = $urandom_range(lo, SAMPLE_MAX);
    case ($urandom_range(0, 5))
      3: c = w[REG_W-1:0];
      4: begin
        c.cal_max = CAL_W'(lo);
        c.cal_min = CAL_W'($urandom_range(lo + 1, (1 << CAL_W) - 1));
        c.cal_mid = w[CAL_W-1:0];
      end
      5: begin
        c.cal_min = CAL_W'(lo);
        c.cal_max = CAL_W'(hi);
        c.cal_mid = w[CAL_W-1:0];
      end
      default: begin
        c.cal_min = CAL_W'(lo);
        c.cal_max = CAL_W'(hi);
        c.cal_mid = CAL_W'($urandom_range(lo, hi));
      end
    endcase
    return c;
  endfunction

  // Random sample, biased toward the calibration points and the rails
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input cal_t c);
    int v;
    case ($urandom_range(0, 5))
      0: v = int'(c.cal_min) + int'($urandom_range(0, 6)) - 3;
      1: v = int'(c.cal_mid) + int'($urandom_range(0, 6)) - 3;
      2: v = int'(c.cal_max) + int'($urandom_range(0, 6)) - 3;
      3: v = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
      default: v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Write all four calibrations from cal_now, setup then access per register
  task automatic load_cal();
    for (int i = 0; i < NUM_CH; i++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_idx_t'(i), 3'b000};
      pwdata  <= APB_DATA_W'(cal_now[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(negedge clk);
      while (!pready) @(negedge clk);
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one sample set after a random gap, hold until accepted
  task automatic push_request(input in_item_t req);
    int gap;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid and wait for every predicted result plus the pipeline tail
  task automatic settle_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random sample sets under the current calibrations
  task automatic run_phase(input int sets);
    in_item_t req;
    in_gaps  = ($urandom_range(0, 3) != 0);
    out_gaps = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < sets; n++) begin
      req.raw_ch0 = pick_sample(cal_now[REG_CAL_CH0]);
      req.raw_ch1 = pick_sample(cal_now[REG_CAL_CH1]);
      req.raw_ch2 = pick_sample(cal_now[REG_CAL_CH2]);
      req.raw_ch3 = pick_sample(cal_now[REG_CAL_CH3]);
      push_request(req);
    end
  endtask

  // Result side: stall a random number of cycles before each result
  initial begin : result_sink
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = out_gaps ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence
  initial begin
    cal_now[REG_CAL_CH0] = CAL_RESET_CENTRED;
    cal_now[REG_CAL_CH1] = CAL_RESET_LEVER;
    cal_now[REG_CAL_CH2] = CAL_RESET_CENTRED;
    cal_now[REG_CAL_CH3] = CAL_RESET_CENTRED;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibrations: rails, centre, alternating bits (ch0, ch1, ch2, ch3)
    push_request({12'h000, 12'h000, 12'h000, 12'h000});
    push_request({12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    push_request({12'h800, 12'h800, 12'h800, 12'h800});
    push_request({12'hAAA, 12'h555, 12'hAAA, 12'h555});
    push_request({12'h555, 12'hAAA, 12'h555, 12'hAAA});
    push_request({12'hFFF, 12'h000, 12'h800, 12'h001});
    push_request({12'h001, 12'hFFE, 12'h7FF, 12'h801});
    push_request({12'h7FF, 12'h801, 12'hFFE, 12'h000});
    settle_results();

    // Corner calibrations: min above max with saturation, zero lever span,
    // empty lower half span, every field at its top value
    cal_now[REG_CAL_CH0] = '{cal_max: 13'd1000, cal_mid: 13'd3500, cal_min: 13'd3000};
    cal_now[REG_CAL_CH1] = '{cal_max: 13'd2000, cal_mid: 13'd0, cal_min: 13'd2000};
    cal_now[REG_CAL_CH2] = '{cal_max: 13'd4095, cal_mid: 13'd0, cal_min: 13'd0};
    cal_now[REG_CAL_CH3] = '1;
    load_cal();
    push_request({12'h000, 12'h000, 12'h000, 12'h000});
    push_request({12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
    push_request({12'd2000, 12'd2000, 12'd2000, 12'd2000});
    push_request({12'd1000, 12'd1999, 12'd1, 12'hFFF});
    push_request({12'd3500, 12'd2001, 12'd2048, 12'd8});
    push_request({12'd3000, 12'd4000, 12'd4094, 12'h800});
    settle_results();

    // All calibrations cleared, then all fields set
    for (int i = 0; i < NUM_CH; i++) cal_now[i] = '0;
    load_cal();
    run_phase(20);
    settle_results();
    for (int i = 0; i < NUM_CH; i++) cal_now[i] = '1;
    load_cal();
    run_phase(20);
    settle_results();

    // Random calibrations with samples aimed at their points
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < NUM_CH; i++) cal_now[i] = pick_cal();
      load_cal();
      run_phase(PHASE_SETS);
      settle_results();
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
